// ----- src/psdsf_pkg.sv -----
// package for the per-source duplicate sequence filter
// widths, table entry type and controller/datapath command type
// no dependencies
`default_nettype none

package psdsf_pkg;

  localparam int unsigned ADDRESS_BITS  = 8;
  localparam int unsigned SEQUENCE_BITS = 16;
  localparam int unsigned COUNT_BITS    = 8;
  localparam int unsigned MAX_BITS      = 8;
  localparam int unsigned TABLE_DEPTH   = 1 << ADDRESS_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_SAT = {COUNT_BITS{1'b1}};

  // action codes
  localparam logic ACT_CHECK = 1'b0;
  localparam logic ACT_RESET = 1'b1;

  localparam logic [MAX_BITS-1:0] MAX_REPEAT_RESET = MAX_BITS'(3);

  typedef logic [ADDRESS_BITS-1:0]  addr_t;
  typedef logic [SEQUENCE_BITS-1:0] seq_t;
  typedef logic [COUNT_BITS-1:0]    count_t;
  typedef logic [MAX_BITS-1:0]      max_t;

  // one table entry
  typedef struct packed {
    seq_t   last_seq;
    count_t count;
  } entry_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the word and launch the table read
    logic execute;  // evaluate, write back and present the result
  } cmd_t;

endpackage

`default_nettype wire

// ----- src/psdsf_ctrl.sv -----
// controller for the duplicate sequence filter
// two-state sequencer: accept a word, then evaluate it; uses psdsf_pkg
`default_nettype none

module psdsf_ctrl
  import psdsf_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start_i,
  output logic busy_o,
  output cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // commands
  assign busy_o        = (state_q == ST_EXEC);
  assign cmd_o.capture = (state_q == ST_IDLE) && start_i;
  assign cmd_o.execute = (state_q == ST_EXEC);

endmodule

`default_nettype wire

// ----- src/psdsf_dpath.sv -----
// datapath for the duplicate sequence filter
// entry table, valid bits, config register and the compare/update logic; uses psdsf_pkg
`default_nettype none

module psdsf_dpath
  import psdsf_pkg::*;
(
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  cmd_t                      cmd_i,
  input  wire                       action_i,
  input  wire  [ADDRESS_BITS-1:0]   address_i,
  input  wire  [SEQUENCE_BITS-1:0]  sequence_req_i,
  input  wire                       cfg_we_i,
  input  wire  [MAX_BITS-1:0]       cfg_wdata_i,
  output logic                      done_o,
  output logic                      duplicate_o
);

  entry_t             mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q;

  logic   action_q;
  addr_t  addr_q;
  seq_t   seq_q;
  entry_t rd_q;
  max_t   max_q;
  logic   done_q;
  logic   dup_q;

  logic   hit;
  seq_t   diff;
  logic   cand;
  logic   wr_en;
  entry_t wr_data;
  logic   dup_d;

  // repeat limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_REPEAT_RESET;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  // word capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      addr_q   <= address_i;
      seq_q    <= sequence_req_i;
    end
  end

  // table: read at capture, write at execute
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_q <= mem[address_i];
    end
    if (wr_en) begin
      mem[addr_q] <= wr_data;
    end
  end

  // serial-number compare at half range
  assign hit  = valid_q[addr_q];
  assign diff = rd_q.last_seq - seq_q;
  assign cand = (addr_q != '0) && !diff[SEQUENCE_BITS-1];

  // entry update
  always_comb begin
    wr_en   = 1'b0;
    wr_data = '{last_seq: seq_q, count: '0};
    dup_d   = 1'b0;
    if (cmd_i.execute) begin
      if (action_q == ACT_RESET) begin
        wr_en   = hit;
        wr_data = '{last_seq: '0, count: '0};
      end else if (!hit) begin
        wr_en = 1'b1;
      end else if (!cand || (COUNT_BITS'(rd_q.count) >= COUNT_BITS'(max_q))) begin
        wr_en = 1'b1;
      end else begin
        wr_en         = 1'b1;
        wr_data.last_seq = rd_q.last_seq;
        wr_data.count = (rd_q.count == COUNT_SAT) ? rd_q.count : rd_q.count + 1'b1;
        dup_d         = 1'b1;
      end
    end
  end

  // valid bits and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      done_q  <= 1'b0;
      dup_q   <= 1'b0;
    end else begin
      done_q <= cmd_i.execute;
      dup_q  <= dup_d;
      if (cmd_i.execute && (action_q == ACT_CHECK)) begin
        valid_q[addr_q] <= 1'b1;
      end
    end
  end

  assign done_o      = done_q;
  assign duplicate_o = dup_q;

endmodule

`default_nettype wire

// ----- src/per_source_duplicate_sequence_filter.sv -----
// Per-source duplicate sequence filter. A word is taken when start is high and
// busy is low; its result is driven on duplicate_o from registers after the
// capture registers, marked by done_o for exactly one cycle; the receiver
// cannot hold it off. A new word may be started in the cycle its predecessor's
// result is shown. A word goes through the registered read of the per-address
// table, then the compare and write-back; busy is high during the compare, so
// no new word is taken then. The table holds the last sequence and repeat
// count for each of 256 addresses; valid bits clear at reset, so no clearing
// pass is needed. max_repeat_count resets to 3; the user must write it through
// cfg_we_i/cfg_wdata_i only while the block is idle, which it does not enforce.
// top level: instantiates psdsf_ctrl and psdsf_dpath; uses psdsf_pkg
`default_nettype none

module per_source_duplicate_sequence_filter
  import psdsf_pkg::*;
(
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start,
  output logic                     busy,
  input  wire                      action_i,
  input  wire [ADDRESS_BITS-1:0]   address_i,
  input  wire [SEQUENCE_BITS-1:0]  sequence_req_i,
  input  wire                      cfg_we_i,
  input  wire [MAX_BITS-1:0]       cfg_wdata_i,
  output logic                     done_o,
  output logic                     duplicate_o
);

  cmd_t cmd;

  // sequencer
  psdsf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  // table and compare
  psdsf_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .action_i       (action_i),
    .address_i      (address_i),
    .sequence_req_i (sequence_req_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .duplicate_o    (duplicate_o)
  );

endmodule

`default_nettype wire
